/* design/rle8_bitmap_decoder_defines.svh */
// assertion macros for the rle8 bitmap decoder
// used by the top level only, no other dependencies
`ifndef RLE8_BITMAP_DECODER_DEFINES_SVH
`define RLE8_BITMAP_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RLE8_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RLE8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rle8_pkg.sv */
// shared types and constants for the rle8 bitmap decoder
// no dependencies
`default_nettype none

package rle8_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 24;

  localparam int DIM_W       = 12;
  localparam int LEN_W       = 24;
  localparam int PIX_ADDR_W  = 24;
  localparam int REGION_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STREAM_LENGTH = 2'd2;

  localparam logic [1:0] KIND_FILL    = 2'd0;
  localparam logic [1:0] KIND_LITERAL = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] CODE_LINE_END  = 8'h00;
  localparam logic [7:0] CODE_IMAGE_END = 8'h01;
  localparam logic [7:0] CODE_REGION    = 8'h02;
  localparam logic [7:0] CODE_SKIP      = 8'h03;

  localparam logic [LEN_W-1:0] SHORT_STREAM = 24'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [PIX_ADDR_W-1:0] pixel_address;
    logic [7:0]            run_length;
    logic [7:0]            colour_index;
    logic                  region_flag;
    logic [REGION_W-1:0]   region_row;
    logic [REGION_W-1:0]   region_column;
    logic                  out_of_frame;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [LEN_W-1:0] stream_length;
  } cfg_t;

  // parser to address stage, coordinates travel beside it
  typedef struct packed {
    logic                valid;
    logic [1:0]          kind;
    logic [7:0]          run_length;
    logic [7:0]          colour_index;
    logic                region_flag;
    logic [REGION_W-1:0] region_row;
    logic [REGION_W-1:0] region_column;
  } cmd_t;

endpackage

`default_nettype wire

/* design/rle8_bitmap_decoder.sv */
// rle8 bitmap decoder: one compressed byte per item, at most one result per item
// a result is registered in cmd, p_cmd and result after its byte is accepted
// one item per cycle unless stalled; row times width multiplier has its own stage
// a one-entry skid buffer on the input keeps item_stall registered
// rst is synchronous: parser state, config registers and pipeline valids clear
// at once, no clearing pass
`default_nettype none
`include "rle8_bitmap_decoder_defines.svh"

module rle8_bitmap_decoder #(
  parameter int COORD_BITS = rle8_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = rle8_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire rle8_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output rle8_pkg::result_t                     result,
  input  wire logic                             cfg_write,
  input  wire logic [rle8_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rle8_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rle8_pkg::*;

  cfg_t                  cfg;
  logic                  skid_valid;
  item_t                 skid_item;
  logic                  advance;
  logic                  src_valid;
  item_t                 src;
  cmd_t                  cmd;
  logic [COORD_BITS-1:0] cmd_row;
  logic [COORD_BITS-1:0] cmd_column;
  logic [COORD_BITS:0]   cmd_column_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[DIM_W-1:0];
        REG_STREAM_LENGTH: cfg.stream_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !(result_valid && result_stall);
  assign item_stall = skid_valid;
  assign src_valid  = skid_valid || item_valid;
  assign src        = skid_valid ? skid_item : item;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (advance) begin
        skid_valid <= 1'b0;
      end
    end else if (item_valid && !advance) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && item_valid && !advance) begin
      skid_item <= item;
    end
  end

  rle8_parse #(
    .COORD_BITS(COORD_BITS)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .src_valid     (src_valid),
    .src           (src),
    .cfg           (cfg),
    .cmd           (cmd),
    .cmd_row       (cmd_row),
    .cmd_column    (cmd_column),
    .cmd_column_end(cmd_column_end)
  );

  rle8_addr #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .cfg           (cfg),
    .cmd           (cmd),
    .cmd_row       (cmd_row),
    .cmd_column    (cmd_column),
    .cmd_column_end(cmd_column_end),
    .result_valid  (result_valid),
    .result        (result)
  );

  `RLE8_ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !advance, skid_valid && $stable(skid_item), "skid item lost while pipeline stalled")
  `RLE8_ASSERT_NOW(a_end_clean, clk, rst, result_valid && result.kind == KIND_END, result.pixel_address == '0 && result.run_length == '0 && !result.out_of_frame, "end of image result carries data")
  `RLE8_ASSERT_NOW(a_literal_single, clk, rst, result_valid && result.kind == KIND_LITERAL, result.run_length == 8'd1 && !result.region_flag, "literal pixel with bad length or region")
  `RLE8_ASSERT_NOW(a_fill_nonzero, clk, rst, result_valid && result.kind == KIND_FILL, result.run_length != '0, "fill run of zero length")

endmodule

`default_nettype wire

/* design/rle8_parse.sv */
// byte parser: phase state, row and column tracking, command register
// depends on rle8_pkg
`default_nettype none

module rle8_parse #(
  parameter int COORD_BITS = rle8_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  src_valid,
  input  wire rle8_pkg::item_t       src,
  input  wire rle8_pkg::cfg_t        cfg,
  output rle8_pkg::cmd_t             cmd,
  output logic [COORD_BITS-1:0]      cmd_row,
  output logic [COORD_BITS-1:0]      cmd_column,
  output logic [COORD_BITS:0]        cmd_column_end
);
  import rle8_pkg::*;

  localparam int CMP_W = COORD_BITS > DIM_W ? COORD_BITS : DIM_W;
  localparam int RGN_EXT_W = COORD_BITS > REGION_W ? COORD_BITS : REGION_W;

  localparam logic [3:0] PH_HDR0    = 4'd0;
  localparam logic [3:0] PH_HDR1    = 4'd1;
  localparam logic [3:0] PH_OP      = 4'd2;
  localparam logic [3:0] PH_COLOUR  = 4'd3;
  localparam logic [3:0] PH_ESC     = 4'd4;
  localparam logic [3:0] PH_XSKIP   = 4'd5;
  localparam logic [3:0] PH_YSKIP   = 4'd6;
  localparam logic [3:0] PH_LITERAL = 4'd7;
  localparam logic [3:0] PH_PAD     = 4'd8;

  logic [3:0]            phase;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] column;
  logic [7:0]            held_count;
  logic [7:0]            literal_remaining;
  logic                  region_pending;
  logic [COORD_BITS-1:0] region_start_row;
  logic [COORD_BITS-1:0] region_start_column;
  logic                  offset_parity;
  logic                  image_done;

  logic [3:0]            base_phase;
  logic [COORD_BITS-1:0] base_row;
  logic [COORD_BITS-1:0] base_column;
  logic [7:0]            base_held;
  logic [7:0]            base_literal;
  logic                  base_region;
  logic [COORD_BITS-1:0] base_region_row;
  logic [COORD_BITS-1:0] base_region_column;
  logic                  base_parity;
  logic                  base_done;

  logic [3:0]            phase_next;
  logic [COORD_BITS-1:0] row_next;
  logic [COORD_BITS-1:0] column_next;
  logic [7:0]            held_count_next;
  logic [7:0]            literal_remaining_next;
  logic                  region_pending_next;
  logic [COORD_BITS-1:0] region_start_row_next;
  logic [COORD_BITS-1:0] region_start_column_next;
  logic                  offset_parity_next;
  logic                  image_done_next;

  logic [7:0]            b;
  logic                  fire;
  logic                  active;
  logic                  do_control;
  logic [COORD_BITS-1:0] row_inc;
  logic [7:0]            literal_dec;
  logic                  emit;
  logic                  finish;
  logic [1:0]            e_kind;
  logic [7:0]            e_len;
  logic [7:0]            e_colour;
  logic                  e_region;
  logic [RGN_EXT_W-1:0]  rgn_row_ext;
  logic [RGN_EXT_W-1:0]  rgn_col_ext;
  cmd_t                  cmd_next;

  assign b    = src.data_byte;
  assign fire = advance && src_valid;

  always_comb begin
    if (src.first_byte) begin
      base_phase         = PH_HDR0;
      base_row           = '0;
      base_column        = '0;
      base_held          = '0;
      base_literal       = '0;
      base_region        = 1'b0;
      base_region_row    = '0;
      base_region_column = '0;
      base_parity        = 1'b0;
      base_done          = 1'b0;
    end else begin
      base_phase         = phase;
      base_row           = row;
      base_column        = column;
      base_held          = held_count;
      base_literal       = literal_remaining;
      base_region        = region_pending;
      base_region_row    = region_start_row;
      base_region_column = region_start_column;
      base_parity        = offset_parity;
      base_done          = image_done;
    end
  end

  always_comb begin
    phase_next               = base_phase;
    row_next                 = base_row;
    column_next              = base_column;
    held_count_next          = base_held;
    literal_remaining_next   = base_literal;
    region_pending_next      = base_region;
    region_start_row_next    = base_region_row;
    region_start_column_next = base_region_column;
    offset_parity_next       = base_parity;
    image_done_next          = base_done;

    emit       = 1'b0;
    finish     = 1'b0;
    do_control = 1'b0;
    e_kind     = KIND_FILL;
    e_len      = '0;
    e_colour   = '0;
    e_region   = 1'b0;

    row_inc     = base_row + 1'b1;
    literal_dec = base_literal - 8'd1;
    active      = !(cfg.stream_length <= SHORT_STREAM) && !base_done;

    if (active) begin
      offset_parity_next = !base_parity;
      case (base_phase)
        PH_HDR0: begin
          if (cfg.frame_height == '0) begin
            finish = 1'b1;
          end else if (b == CODE_LINE_END) begin
            phase_next = PH_HDR1;
          end else begin
            held_count_next = b;
            phase_next      = PH_COLOUR;
          end
        end
        PH_HDR1: begin
          if (b == CODE_LINE_END) begin
            phase_next = PH_OP;
          end else begin
            do_control = 1'b1;
          end
        end
        PH_OP: begin
          if (b == CODE_LINE_END) begin
            phase_next = PH_ESC;
          end else begin
            held_count_next = b;
            phase_next      = PH_COLOUR;
          end
        end
        PH_COLOUR: begin
          emit                = 1'b1;
          e_kind              = KIND_FILL;
          e_len               = base_held;
          e_colour            = b;
          e_region            = base_region;
          region_pending_next = 1'b0;
          column_next         = base_column + COORD_BITS'(base_held);
          phase_next          = PH_OP;
        end
        PH_ESC: begin
          do_control = 1'b1;
        end
        PH_XSKIP: begin
          column_next = base_column + COORD_BITS'(b);
          phase_next  = PH_YSKIP;
        end
        PH_YSKIP: begin
          row_next   = base_row + COORD_BITS'(b);
          phase_next = PH_OP;
        end
        PH_LITERAL: begin
          emit                   = 1'b1;
          e_kind                 = KIND_LITERAL;
          e_len                  = 8'd1;
          e_colour               = b;
          column_next            = base_column + 1'b1;
          literal_remaining_next = literal_dec;
          if (literal_dec == '0) begin
            phase_next = base_parity ? PH_OP : PH_PAD;
          end
        end
        default: begin
          phase_next = PH_OP;
        end
      endcase

      if (do_control) begin
        phase_next = PH_OP;
        case (b)
          CODE_LINE_END: begin
            row_next            = row_inc;
            column_next         = '0;
            region_pending_next = 1'b0;
            if (CMP_W'(row_inc) >= CMP_W'(cfg.frame_height)) begin
              finish = 1'b1;
            end
          end
          CODE_IMAGE_END: begin
            finish = 1'b1;
          end
          CODE_REGION: begin
            region_pending_next      = 1'b1;
            region_start_row_next    = base_row;
            region_start_column_next = base_column;
          end
          CODE_SKIP: begin
            phase_next = PH_XSKIP;
          end
          default: begin
            literal_remaining_next = b;
            phase_next             = PH_LITERAL;
          end
        endcase
      end

      if (finish) begin
        image_done_next = 1'b1;
        emit            = 1'b1;
        e_kind          = KIND_END;
      end
    end
  end

  assign rgn_row_ext = RGN_EXT_W'(base_region_row);
  assign rgn_col_ext = RGN_EXT_W'(base_region_column);

  always_comb begin
    cmd_next.valid         = fire && emit;
    cmd_next.kind          = e_kind;
    cmd_next.run_length    = e_len;
    cmd_next.colour_index  = e_colour;
    cmd_next.region_flag   = e_region;
    cmd_next.region_row    = e_region ? rgn_row_ext[REGION_W-1:0] : '0;
    cmd_next.region_column = e_region ? rgn_col_ext[REGION_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HDR0;
      row                 <= '0;
      column              <= '0;
      held_count          <= '0;
      literal_remaining   <= '0;
      region_pending      <= 1'b0;
      region_start_row    <= '0;
      region_start_column <= '0;
      offset_parity       <= 1'b0;
      image_done          <= 1'b0;
    end else if (fire) begin
      phase               <= phase_next;
      row                 <= row_next;
      column              <= column_next;
      held_count          <= held_count_next;
      literal_remaining   <= literal_remaining_next;
      region_pending      <= region_pending_next;
      region_start_row    <= region_start_row_next;
      region_start_column <= region_start_column_next;
      offset_parity       <= offset_parity_next;
      image_done          <= image_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd <= '0;
    end else if (advance) begin
      cmd <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_row        <= base_row;
      cmd_column     <= base_column;
      cmd_column_end <= {1'b0, base_column} + (COORD_BITS + 1)'(e_len);
    end
  end

endmodule

`default_nettype wire

/* design/rle8_addr.sv */
// address stage: row times width product, then address and frame bound check
// depends on rle8_pkg
`default_nettype none

module rle8_addr #(
  parameter int COORD_BITS = rle8_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = rle8_pkg::ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire rle8_pkg::cfg_t        cfg,
  input  wire rle8_pkg::cmd_t        cmd,
  input  wire logic [COORD_BITS-1:0] cmd_row,
  input  wire logic [COORD_BITS-1:0] cmd_column,
  input  wire logic [COORD_BITS:0]   cmd_column_end,
  output logic                       result_valid,
  output rle8_pkg::result_t          result
);
  import rle8_pkg::*;

  localparam int PROD_W = COORD_BITS + DIM_W;
  localparam int SUM_W  = (COORD_BITS + DIM_W + 1) > PIX_ADDR_W ?
                          (COORD_BITS + DIM_W + 1) : PIX_ADDR_W;
  localparam int KEEP_W = ADDR_BITS < SUM_W ? ADDR_BITS : SUM_W;
  localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - KEEP_W);

  cmd_t                  p_cmd;
  logic [PROD_W-1:0]     p_prod;
  logic [COORD_BITS-1:0] p_column;
  logic [COORD_BITS:0]   p_column_end;
  logic [2*DIM_W-1:0]    area;

  logic [SUM_W-1:0]      addr_full;
  logic [SUM_W-1:0]      end_full;
  logic [SUM_W-1:0]      addr_keep;
  result_t               result_next;

  // width and height must only move while idle (unenforced): area is registered
  always_ff @(posedge clk) begin
    area <= cfg.frame_width * cfg.frame_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_cmd <= '0;
    end else if (advance) begin
      p_cmd <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_prod       <= PROD_W'(cmd_row) * PROD_W'(cfg.frame_width);
      p_column     <= cmd_column;
      p_column_end <= cmd_column_end;
    end
  end

  assign addr_full = SUM_W'(p_prod) + SUM_W'(p_column);
  assign end_full  = SUM_W'(p_prod) + SUM_W'(p_column_end);
  assign addr_keep = addr_full & ADDR_MASK;

  always_comb begin
    result_next = '0;
    result_next.kind = p_cmd.kind;
    if (p_cmd.kind != KIND_END) begin
      result_next.pixel_address = addr_keep[PIX_ADDR_W-1:0];
      result_next.run_length    = p_cmd.run_length;
      result_next.colour_index  = p_cmd.colour_index;
      result_next.region_flag   = p_cmd.region_flag;
      result_next.region_row    = p_cmd.region_row;
      result_next.region_column = p_cmd.region_column;
      result_next.out_of_frame  = end_full > SUM_W'(area);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= p_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
